### design/pidaw_pkg.sv
// ----------------------------------------------------------------------------
// pidaw_pkg: shared types, constants and helpers for the PID step unit
// Q16.16 widths, register indexes, configuration bundle and saturation.
// ----------------------------------------------------------------------------
package pidaw_pkg;

	localparam int Q_W     = 32;
	localparam int FRAC_W  = 16;
	localparam int PROD_W  = 2 * Q_W;
	localparam int SAT_W   = PROD_W - FRAC_W;
	localparam int IDX_W   = 3;
	localparam int OUT_W   = 72;

	localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

	typedef enum logic [IDX_W-1:0] {
		REG_LIMIT_HIGH  = 3'd0,
		REG_LIMIT_LOW   = 3'd1,
		REG_KP          = 3'd2,
		REG_KI          = 3'd3,
		REG_KD          = 3'd4,
		REG_ANGLE_SCALE = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [Q_W-1:0] limit_high;
		logic signed [Q_W-1:0] limit_low;
		logic signed [Q_W-1:0] kp;
		logic signed [Q_W-1:0] ki;
		logic signed [Q_W-1:0] kd;
		logic signed [Q_W-1:0] angle_scale;
	} cfg_t;

	// clamp a wide signed value into the Q16.16 range
	function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SAT_W-1:0] x);
		logic signed [Q_W-1:0] r;
		if (x > SAT_W'(Q_MAX)) begin
			r = Q_MAX;
		end else if (x < SAT_W'(Q_MIN)) begin
			r = Q_MIN;
		end else begin
			r = x[Q_W-1:0];
		end
		return r;
	endfunction

endpackage

### design/pidaw_regs.sv
// ----------------------------------------------------------------------------
// pidaw_regs: configuration register file
// Six Q16.16 registers written through a valid/ready channel.
// ----------------------------------------------------------------------------
module pidaw_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [pidaw_pkg::IDX_W-1:0] cfg_index,
	input  logic [pidaw_pkg::Q_W-1:0]   cfg_data,
	output pidaw_pkg::cfg_t             cfg
);
	import pidaw_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			// indexes past the list drop the write
			unique case (reg_idx_t'(cfg_index))
				REG_LIMIT_HIGH:  cfg_q.limit_high  <= cfg_data;
				REG_LIMIT_LOW:   cfg_q.limit_low   <= cfg_data;
				REG_KP:          cfg_q.kp          <= cfg_data;
				REG_KI:          cfg_q.ki          <= cfg_data;
				REG_KD:          cfg_q.kd          <= cfg_data;
				REG_ANGLE_SCALE: cfg_q.angle_scale <= cfg_data;
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

endmodule

### design/pidaw_mul.sv
// ----------------------------------------------------------------------------
// pidaw_mul: shared Q16.16 multiplier
// Registers the full product, then rounds to nearest (ties up) and saturates.
// ----------------------------------------------------------------------------
module pidaw_mul (
	input  logic                              clk,
	input  logic signed [pidaw_pkg::Q_W-1:0]  a,
	input  logic signed [pidaw_pkg::Q_W-1:0]  b,
	output logic signed [pidaw_pkg::Q_W-1:0]  res
);
	import pidaw_pkg::*;

	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] rounded;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

	// product magnitude is at most 2^62, so the rounding add cannot wrap
	assign rounded = prod_q + PROD_W'(64'sd32768);
	assign res     = sat_q(rounded[PROD_W-1:FRAC_W]);

endmodule

### design/pid_antiwindup_angle_step_unit.sv
// ----------------------------------------------------------------------------
// pid_antiwindup_angle_step_unit: PID step with conditional integration
// Drive = kp*e + integral + kd*(e - e_prev); angle from the drive second
// difference. One shared multiplier is stepped by a small sequencer.
// ----------------------------------------------------------------------------
// Flow: an accepted word goes through four passes of the single multiplier
// plus the two saturating sum steps before the result word is loaded; a
// stalled output holds the sequencer in S_FIN until the register frees up.
// Input is taken again as soon as the result sits in the output register.
// Reset: asynchronous, active low; clears registers, integral and history.
module pid_antiwindup_angle_step_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [pidaw_pkg::Q_W-1:0]   s_tdata,   // [31:0] error_sample
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [pidaw_pkg::OUT_W-1:0] m_tdata,   // [31:0] drive, [63:32] angle,
	                                               // [64] windup_hold, [71:65] zero
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [pidaw_pkg::IDX_W-1:0] cfg_index,
	input  logic [pidaw_pkg::Q_W-1:0]   cfg_data
);
	import pidaw_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_MKI, S_MKP, S_MKD, S_SUM, S_D2, S_MAN, S_FIN
	} state_t;

	state_t state_q;
	cfg_t   cfg;

	logic signed [Q_W-1:0] e_q;
	logic signed [Q_W-1:0] diff_q;
	logic                  hold_q;
	logic signed [Q_W-1:0] pterm_q;
	logic signed [Q_W-1:0] drive_q;
	logic signed [Q_W-1:0] d2_q;
	logic signed [Q_W-1:0] integral_q;
	logic signed [Q_W-1:0] last_error_q;
	logic signed [Q_W-1:0] last_drive_q;
	logic signed [Q_W-1:0] second_last_drive_q;
	logic                  m_tvalid_q;
	logic [OUT_W-1:0]      m_tdata_q;

	logic signed [Q_W-1:0] e_in;
	logic                  hold_in;
	logic signed [Q_W-1:0] mul_a;
	logic signed [Q_W-1:0] mul_b;
	logic signed [Q_W-1:0] mul_res;

	pidaw_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pidaw_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.res (mul_res)
	);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign e_in    = $signed(s_tdata);
	assign hold_in = ((last_drive_q > cfg.limit_high) && (e_in > 0)) ||
	                 ((last_drive_q < cfg.limit_low)  && (e_in < 0));

	// operand select: the product shows up at mul_res in the next cycle
	always_comb begin
		unique case (state_q)
			S_MKI:        begin mul_a = cfg.ki;          mul_b = e_q;    end
			S_MKP:        begin mul_a = cfg.kp;          mul_b = e_q;    end
			S_MKD:        begin mul_a = cfg.kd;          mul_b = diff_q; end
			S_MAN, S_FIN: begin mul_a = cfg.angle_scale; mul_b = d2_q;   end
			default:      begin mul_a = cfg.ki;          mul_b = e_q;    end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q             <= S_IDLE;
			m_tvalid_q          <= 1'b0;
			m_tdata_q           <= '0;
			e_q                 <= '0;
			diff_q              <= '0;
			hold_q              <= 1'b0;
			pterm_q             <= '0;
			drive_q             <= '0;
			d2_q                <= '0;
			integral_q          <= '0;
			last_error_q        <= '0;
			last_drive_q        <= '0;
			second_last_drive_q <= '0;
		end else begin
			// drop valid on handoff unless a new word loads in the same cycle
			if (m_tvalid_q && m_tready && (state_q != S_FIN)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						e_q     <= e_in;
						hold_q  <= hold_in;
						diff_q  <= sat_q(SAT_W'(e_in) - SAT_W'(last_error_q));
						state_q <= S_MKI;
					end
				end
				S_MKI: begin
					state_q <= S_MKP;
				end
				S_MKP: begin
					// ki*e is ready; skip integration while held
					if (!hold_q) begin
						integral_q <= sat_q(SAT_W'(integral_q) + SAT_W'(mul_res));
					end
					state_q <= S_MKD;
				end
				S_MKD: begin
					pterm_q <= mul_res;
					state_q <= S_SUM;
				end
				S_SUM: begin
					drive_q <= sat_q(SAT_W'(pterm_q) + SAT_W'(integral_q) + SAT_W'(mul_res));
					state_q <= S_D2;
				end
				S_D2: begin
					d2_q <= sat_q(SAT_W'(drive_q) - (SAT_W'(last_drive_q) <<< 1)
					              + SAT_W'(second_last_drive_q));
					state_q <= S_MAN;
				end
				S_MAN: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					// hold here until the output register frees up
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q           <= {7'b0, hold_q, mul_res, drive_q};
						m_tvalid_q          <= 1'b1;
						second_last_drive_q <= last_drive_q;
						last_drive_q        <= drive_q;
						last_error_q        <= e_q;
						state_q             <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### design/pidaw_checker.sv
// ----------------------------------------------------------------------------
// pidaw_port_checks: port-level checks for the PID step unit
// Busy window after each accepted word, output stability, padding bits.
// ----------------------------------------------------------------------------
module pidaw_port_checks (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [pidaw_pkg::OUT_W-1:0] m_tdata
);

	// the sequencer stays busy after taking a word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready ##1 !s_tready ##1 !s_tready)
		else $error("input taken again too soon after an accept");

	// a new result only appears at the end of a busy window
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result word appeared without work in progress");

	// no new result while the sequencer is idle and nothing was pending
	a_idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tready && !m_tvalid && !(s_tvalid && s_tready)) |=> !m_tvalid)
		else $error("result word appeared from an idle unit");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result word changed");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[71:65] == 7'b0))
		else $error("padding bits of result word not zero");

endmodule

bind pid_antiwindup_angle_step_unit pidaw_port_checks u_pidaw_checker (.*);

### bench/pidaw_checker.sv
// ----------------------------------------------------------------------------
// pidaw_checker: scoreboard for the PID anti-windup angle step unit
// Tracks register writes and accepted error words, predicts drive, angle and
// windup hold for each one, and compares them in order with the result words.
// ----------------------------------------------------------------------------
module pidaw_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	input  logic                        s_tready,
	input  logic [pidaw_pkg::Q_W-1:0]   s_tdata,
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [pidaw_pkg::OUT_W-1:0] m_tdata,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [pidaw_pkg::IDX_W-1:0] cfg_index,
	input  logic [pidaw_pkg::Q_W-1:0]   cfg_data,
	output int                          mismatches,
	output int                          awaiting
);
	import pidaw_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [Q_W-1:0] drive;
		logic [Q_W-1:0] angle;
		logic           hold;
	} pid_result_t;

	pid_result_t drive_q[$];

	// predictor copy of the registers and loop history
	longint lim_hi, lim_lo, gain_p, gain_i, gain_d, angle_gain;
	longint integ_acc, prev_err, drive_d1, drive_d2;

	int fault_count = 0;
	int queued_n = 0;

	assign mismatches = fault_count;
	assign awaiting   = queued_n;

	task automatic report_mismatch(input string what);
		if (fault_count < 40) begin
			$display("%0t checker: %s", $realtime, what);
		end
		fault_count++;
	endtask

	function automatic longint clamp32(input longint x);
		if (x > longint'(Q_MAX)) begin
			return longint'(Q_MAX);
		end
		if (x < longint'(Q_MIN)) begin
			return longint'(Q_MIN);
		end
		return x;
	endfunction

	// Q16.16 product: round half up, then clamp
	function automatic longint qmul16(input longint a, input longint b);
		longint p;
		p = a * b + 64'sd32768;
		return clamp32(p >>> FRAC_W);
	endfunction

	task automatic apply_reg(input logic [IDX_W-1:0] idx, input logic [Q_W-1:0] val);
		longint v;
		v = longint'($signed(val));
		case (reg_idx_t'(idx))
			REG_LIMIT_HIGH:  lim_hi = v;
			REG_LIMIT_LOW:   lim_lo = v;
			REG_KP:          gain_p = v;
			REG_KI:          gain_i = v;
			REG_KD:          gain_d = v;
			REG_ANGLE_SCALE: angle_gain = v;
			default: ;
		endcase
	endtask

	task automatic step_pid(input longint e, output pid_result_t r);
		longint prev, prevprev, diff, drv, d2, ang;
		bit     hold;
		prev     = drive_d1;
		prevprev = drive_d2;
		hold = (prev > lim_hi && e > 0) || (prev < lim_lo && e < 0);
		if (!hold) begin
			integ_acc = clamp32(integ_acc + qmul16(gain_i, e));
		end
		diff = clamp32(e - prev_err);
		drv  = clamp32(qmul16(gain_p, e) + integ_acc + qmul16(gain_d, diff));
		d2   = clamp32(drv - 2 * prev + prevprev);
		ang  = qmul16(angle_gain, d2);
		r.drive = drv[Q_W-1:0];
		r.angle = ang[Q_W-1:0];
		r.hold  = hold;
		drive_d2 = prev;
		drive_d1 = drv;
		prev_err = e;
	endtask

	always @(posedge clk or negedge arst_n) begin
		pid_result_t want;
		if (!arst_n) begin
			lim_hi = 0;
			lim_lo = 0;
			gain_p = 0;
			gain_i = 0;
			gain_d = 0;
			angle_gain = 0;
			integ_acc = 0;
			prev_err = 0;
			drive_d1 = 0;
			drive_d2 = 0;
			drive_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				apply_reg(cfg_index, cfg_data);
			end
			if (s_tvalid && s_tready) begin
				step_pid(longint'($signed(s_tdata)), want);
				drive_q.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				if (drive_q.size() == 0) begin
					report_mismatch($sformatf("result word %h with nothing expected", m_tdata));
				end else begin
					want = drive_q.pop_front();
					if (m_tdata[31:0] !== want.drive) begin
						report_mismatch($sformatf("drive %h, expected %h",
							m_tdata[31:0], want.drive));
					end
					if (m_tdata[63:32] !== want.angle) begin
						report_mismatch($sformatf("angle %h, expected %h",
							m_tdata[63:32], want.angle));
					end
					if (m_tdata[64] !== want.hold) begin
						report_mismatch($sformatf("windup_hold %b, expected %b",
							m_tdata[64], want.hold));
					end
					if (m_tdata[OUT_W-1:65] !== '0) begin
						report_mismatch($sformatf("pad bits %h not zero", m_tdata[OUT_W-1:65]));
					end
				end
			end
		end
		queued_n = drive_q.size();
	end

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the PID anti-windup angle step unit
// Drives register writes and error words with random gaps and output stalls;
// the checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench;
	import pidaw_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [IDX_W-1:0] IDX_SPARE_A = 3'd6;
	localparam logic [IDX_W-1:0] IDX_SPARE_B = 3'd7;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [Q_W-1:0]   s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index;
	logic [Q_W-1:0]   cfg_data;

	int mismatches;
	int in_flight;
	int tx_gap_pct = 20;
	int rx_stall_pct = 20;

	pid_antiwindup_angle_step_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pidaw_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.awaiting   (in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// output backpressure in bursts
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0 && rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct) begin
				stall_left = $urandom_range(1, 13);
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("testbench: done, errors");
		$finish;
	end

	// leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [Q_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic load_regs(input logic [Q_W-1:0] hi, input logic [Q_W-1:0] lo,
		input logic [Q_W-1:0] p, input logic [Q_W-1:0] i, input logic [Q_W-1:0] d,
		input logic [Q_W-1:0] a);
		write_reg($urandom_range(0, 1) ? IDX_SPARE_A : IDX_SPARE_B, $urandom());
		write_reg(REG_LIMIT_HIGH, hi);
		write_reg(REG_LIMIT_LOW, lo);
		write_reg(REG_KP, p);
		write_reg(REG_KI, i);
		write_reg(REG_KD, d);
		write_reg(REG_ANGLE_SCALE, a);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_error(input logic [Q_W-1:0] e);
		s_tvalid <= 1'b1;
		s_tdata  <= e;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
	endtask

	// hold input until every predicted word has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (in_flight != 0);
	endtask

	function automatic logic [Q_W-1:0] pick_gain();
		case ($urandom_range(0, 11))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			3: return $urandom();
			default: return Q_W'(int'($urandom_range(0, 262144)) - 131072);
		endcase
	endfunction

	function automatic logic [Q_W-1:0] pick_error();
		case ($urandom_range(0, 15))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			3, 4: return $urandom();
			5: return Q_W'(int'($urandom_range(0, 16)) - 8);
			default: return Q_W'(int'($urandom_range(0, 40 << 16)) - (20 << 16));
		endcase
	endfunction

	function automatic int pick_pct();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 5;
			2: return 20;
			default: return 50;
		endcase
	endfunction

	initial begin
		int ph, k;
		logic [Q_W-1:0] hi, lo;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: everything zero
		send_error(32'h0001_0000);
		drain();

		// moderate gains, limits at +/-10.0
		load_regs(32'h000A_0000, 32'hFFF6_0000, 32'h0001_0000, 32'h0000_8000,
			32'h0000_4000, 32'h0000_1872);
		send_error(32'h0000_0000);
		send_error(32'h0000_0001);
		send_error(32'hFFFF_FFFF);
		repeat (4) send_error(32'h0004_0000);
		// drive now above the high limit: positive error holds, zero does not
		send_error(32'h0002_0000);
		send_error(32'h0000_0000);
		repeat (3) send_error(32'hFFF0_0000);
		send_error(32'hFFFF_0000);
		send_error(Q_MAX);
		send_error(Q_MIN);
		send_error(Q_MIN);
		send_error(Q_MAX);
		drain();

		// maximum gains, crossed limits
		load_regs(Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN);
		send_error(Q_MAX);
		send_error(Q_MIN);
		send_error(32'h0000_0001);
		send_error(32'h0000_0000);
		drain();

		// minimum gains, widest limits
		load_regs(Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX);
		send_error(Q_MIN);
		send_error(Q_MAX);
		send_error(Q_MIN);

		for (ph = 0; ph < 8; ph++) begin
			drain();
			if (ph == 7) begin
				tx_gap_pct = 0;
				rx_stall_pct = 0;
			end else begin
				tx_gap_pct = pick_pct();
				rx_stall_pct = pick_pct();
			end
			case ($urandom_range(0, 5))
				0: begin
					hi = Q_W'(-int'($urandom_range(0, 50 << 16)));
					lo = Q_W'(int'($urandom_range(0, 50 << 16)));
				end
				1: begin
					hi = Q_MAX;
					lo = Q_MIN;
				end
				2: begin
					hi = $urandom();
					lo = $urandom();
				end
				default: begin
					hi = Q_W'(int'($urandom_range(0, 100 << 16)));
					lo = Q_W'(-int'($urandom_range(0, 100 << 16)));
				end
			endcase
			load_regs(hi, lo, pick_gain(), pick_gain(), pick_gain(), pick_gain());
			for (k = 0; k < 250; k++) begin
				if (ph == 2 && k == 125) begin
					drain();
				end
				send_error(pick_error());
			end
		end
		drain();
		repeat (16) @(negedge clk);

		if (mismatches == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
